// File: rtl/pidct_pkg.sv
`default_nettype none
package pidct_pkg;

	// item kinds
	localparam logic [1:0] KIND_UPDATE = 2'd0;
	localparam logic [1:0] KIND_PRESET = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN   = 3'd2;
	localparam logic [2:0] REG_DERIV_FILTER = 3'd3;
	localparam logic [2:0] REG_PROP_LIMIT   = 3'd4;
	localparam logic [2:0] REG_INTEG_LIMIT  = 3'd5;
	localparam logic [2:0] REG_DERIV_LIMIT  = 3'd6;
	localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd7;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} pidct_stat_t;

endpackage
`default_nettype wire

// File: rtl/pidct_mul.sv
`default_nettype none
// Bit-serial signed fixed-point multiply: shift-add on magnitudes, one
// multiplier bit per cycle, then truncate by FRAC_BITS and saturate.
module pidct_mul #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    go,
	input  wire logic [VALUE_WIDTH-1:0]  a,
	input  wire logic [VALUE_WIDTH-1:0]  b,
	output pidct_pkg::pidct_stat_t       stat,
	output logic      [VALUE_WIDTH-1:0]  res
);
	import pidct_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int MW = 2*W - F;
	localparam int CW = $clog2(W);

	logic          busy_q, fin_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  mcand_q, hi_q, lo_q, res_q;
	logic [W:0]    step_sum;
	logic [MW-1:0] mag;
	logic          over;

	assign step_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : {(W+1){1'b0}});
	assign mag = MW'({hi_q, lo_q} >> F);
	assign over = neg_q ? ((|mag[MW-1:W]) || (mag[W-1] && (|mag[W-2:0])))
	                    : (|mag[MW-1:W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W-1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q   <= a[W-1] ^ b[W-1];
			mcand_q <= a[W-1] ? (W'(0) - a) : a;
			lo_q    <= b[W-1] ? (W'(0) - b) : b;
			hi_q    <= '0;
		end else if (busy_q) begin
			hi_q <= step_sum[W:1];
			lo_q <= {step_sum[0], lo_q[W-1:1]};
		end else if (fin_q) begin
			if (neg_q)
				res_q <= over ? {1'b1, {(W-1){1'b0}}} : (W'(0) - mag[W-1:0]);
			else
				res_q <= over ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
		end
	end

	assign stat.busy = busy_q | fin_q;
	assign stat.done = done_q;
	assign res = res_q;

endmodule
`default_nettype wire

// File: rtl/pidct_div.sv
`default_nettype none
// Bit-serial restoring divide: (num << FRAC_BITS) / den on magnitudes,
// one quotient bit per cycle, truncated toward zero and saturated.
module pidct_div #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    go,
	input  wire logic [VALUE_WIDTH-1:0]  num,
	input  wire logic [VALUE_WIDTH-1:0]  den,
	output pidct_pkg::pidct_stat_t       stat,
	output logic      [VALUE_WIDTH-1:0]  res
);
	import pidct_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int Q  = W + F;
	localparam int CW = $clog2(Q);

	logic          busy_q, fin_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [Q-1:0]  dq_q;
	logic [W-1:0]  rem_q, d_q, res_q;
	logic [W:0]    r2, r2_sub;
	logic          ge, over;

	assign r2     = {rem_q, dq_q[Q-1]};
	assign r2_sub = r2 - {1'b0, d_q};
	assign ge     = (r2 >= {1'b0, d_q});
	assign over = neg_q ? ((|dq_q[Q-1:W]) || (dq_q[W-1] && (|dq_q[W-2:0])))
	                    : (|dq_q[Q-1:W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(Q-1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= num[W-1] ^ den[W-1];
			dq_q  <= {(num[W-1] ? (W'(0) - num) : num), {F{1'b0}}};
			d_q   <= den[W-1] ? (W'(0) - den) : den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? r2_sub[W-1:0] : r2[W-1:0];
			dq_q  <= {dq_q[Q-2:0], ge};
		end else if (fin_q) begin
			if (neg_q)
				res_q <= over ? {1'b1, {(W-1){1'b0}}} : (W'(0) - dq_q[W-1:0]);
			else
				res_q <= over ? {1'b0, {(W-1){1'b1}}} : dq_q[W-1:0];
		end
	end

	assign stat.busy = busy_q | fin_q;
	assign stat.done = done_q;
	assign res = res_q;

endmodule
`default_nettype wire

// File: rtl/pid_controller_clamped_terms.sv
// An update runs the bit-serial multiplier up to six times (P, I and D terms) and the serial
//   divider at most once for clamp-back; a preset may run the serial divider, a clear neither.
// Throughput: one item at a time; the next transfer is taken once drive is latched.
// Reset (async, arst_n low): gains 0, filter 1.0, limits full scale, state zero.
`default_nettype none
module pid_controller_clamped_terms #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [VALUE_WIDTH-1:0] cfg_data,
	// input channel
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             kind,
	input  wire logic [VALUE_WIDTH-1:0] target,
	input  wire logic [VALUE_WIDTH-1:0] measured,
	input  wire logic [FRAC_BITS-1:0]   time_step,
	input  wire logic [VALUE_WIDTH-1:0] integ_preset,
	// output channel
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [VALUE_WIDTH-1:0]      drive
);
	import pidct_pkg::*;

	localparam int W = VALUE_WIDTH;
	localparam int F = FRAC_BITS;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PREP = 4'd1;
	localparam logic [3:0] S_P    = 4'd2;   // P product
	localparam logic [3:0] S_I1   = 4'd3;   // integ_gain * error_sum
	localparam logic [3:0] S_I2   = 4'd4;   // ... * time_step
	localparam logic [3:0] S_IDIV = 4'd5;   // clamp-back or preset divide
	localparam logic [3:0] S_D0   = 4'd6;
	localparam logic [3:0] S_D1   = 4'd7;   // deriv_gain * filter
	localparam logic [3:0] S_D2   = 4'd8;   // ... * diff
	localparam logic [3:0] S_D3   = 4'd9;   // filter * diff into memory
	localparam logic [3:0] S_SUM  = 4'd10;

	// saturate a one-bit-grown value back to W bits
	function automatic logic [W-1:0] sat1(input logic [W:0] v);
		if (v[W] != v[W-1])
			sat1 = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else
			sat1 = v[W-1:0];
	endfunction

	// saturate a two-bit-grown value (three-term sum)
	function automatic logic [W-1:0] sat2(input logic [W+1:0] v);
		if (v[W+1] == v[W] && v[W] == v[W-1])
			sat2 = v[W-1:0];
		else
			sat2 = v[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
	endfunction

	// symmetric clamp to +/- lim
	function automatic logic [W-1:0] clampsym(input logic [W-1:0] v,
	                                          input logic [W-2:0] lim);
		logic signed [W-1:0] pl;
		logic signed [W-1:0] nl;
		pl = $signed({1'b0, lim});
		nl = -pl;
		if ($signed(v) > pl)
			clampsym = pl;
		else if ($signed(v) < nl)
			clampsym = nl;
		else
			clampsym = v;
	endfunction

	// configuration registers
	logic [W-1:0] pgain_q, igain_q, dgain_q;
	logic [F:0]   dfilt_q;
	logic [W-2:0] plim_q, ilim_q, dlim_q, olim_q;

	// controller state
	logic [W-1:0] esum_q, dmem_q;

	// sequencer and working registers
	logic [3:0]   state_q;
	logic [1:0]   kind_q;
	logic [W-1:0] tgt_q, meas_q, preset_q;
	logic [F-1:0] dt_q;
	logic [W-1:0] pt_q, it_q, dterm_q, diff_q;
	logic [W-1:0] drive_q;
	logic         out_valid_q;

	// serial unit requests
	logic         mul_go_q, div_go_q;
	logic [W-1:0] mul_a_q, mul_b_q, div_n_q, div_d_q;
	pidct_stat_t  mul_stat, div_stat;
	logic [W-1:0] mul_res, div_res;

	pidct_mul #(.VALUE_WIDTH(W), .FRAC_BITS(F)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.stat   (mul_stat),
		.res    (mul_res)
	);

	pidct_div #(.VALUE_WIDTH(W), .FRAC_BITS(F)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (div_n_q),
		.den    (div_d_q),
		.stat   (div_stat),
		.res    (div_res)
	);

	// narrow add/subtract with saturation, and the term clamps, used across the sequencer steps
	logic [W-1:0] err_c, esum_c, negm_c, diff_c, dmem_c, itc_c, sum_c;

	assign err_c  = sat1({tgt_q[W-1], tgt_q} - {meas_q[W-1], meas_q});
	assign esum_c = sat1({esum_q[W-1], esum_q} + {err_c[W-1], err_c});
	assign negm_c = sat1((W+1)'(0) - {meas_q[W-1], meas_q});
	assign diff_c = sat1({negm_c[W-1], negm_c} - {dmem_q[W-1], dmem_q});
	assign dmem_c = sat1({dmem_q[W-1], dmem_q} + {mul_res[W-1], mul_res});
	assign itc_c  = clampsym(mul_res, ilim_q);
	assign sum_c  = sat2({{2{pt_q[W-1]}}, pt_q} + {{2{it_q[W-1]}}, it_q}
	                     + {{2{dterm_q[W-1]}}, dterm_q});

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pgain_q <= '0;
			igain_q <= '0;
			dgain_q <= '0;
			dfilt_q <= {1'b1, {F{1'b0}}};
			plim_q  <= '1;
			ilim_q  <= '1;
			dlim_q  <= '1;
			olim_q  <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:    pgain_q <= cfg_data;
				REG_INTEG_GAIN:   igain_q <= cfg_data;
				REG_DERIV_GAIN:   dgain_q <= cfg_data;
				REG_DERIV_FILTER: dfilt_q <= cfg_data[F:0];
				REG_PROP_LIMIT:   plim_q  <= cfg_data[W-2:0];
				REG_INTEG_LIMIT:  ilim_q  <= cfg_data[W-2:0];
				REG_DERIV_LIMIT:  dlim_q  <= cfg_data[W-2:0];
				REG_OUTPUT_LIMIT: olim_q  <= cfg_data[W-2:0];
				default: ;
			endcase
		end
	end

	// sequencer: control and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mul_go_q    <= 1'b0;
			div_go_q    <= 1'b0;
			esum_q      <= '0;
			dmem_q      <= '0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_PREP;
				end
				S_PREP: begin
					case (kind_q)
						KIND_UPDATE: begin
							esum_q   <= esum_c;
							mul_go_q <= 1'b1;
							state_q  <= S_P;
						end
						KIND_PRESET: begin
							dmem_q <= negm_c;
							if (igain_q != '0) begin
								div_go_q <= 1'b1;
								state_q  <= S_IDIV;
							end else begin
								state_q <= S_SUM;
							end
						end
						KIND_CLEAR: begin
							esum_q  <= '0;
							dmem_q  <= '0;
							state_q <= S_SUM;
						end
						default: state_q <= S_SUM;
					endcase
				end
				S_P: begin
					if (mul_stat.done) begin
						mul_go_q <= 1'b1;
						state_q  <= S_I1;
					end
				end
				S_I1: begin
					if (mul_stat.done) begin
						mul_go_q <= 1'b1;
						state_q  <= S_I2;
					end
				end
				S_I2: begin
					if (mul_stat.done) begin
						// clamp-back only when the term clamped and the gain is nonzero
						if (itc_c != mul_res && igain_q != '0) begin
							div_go_q <= 1'b1;
							state_q  <= S_IDIV;
						end else begin
							state_q <= S_D0;
						end
					end
				end
				S_IDIV: begin
					if (div_stat.done) begin
						esum_q  <= div_res;
						state_q <= (kind_q == KIND_UPDATE) ? S_D0 : S_SUM;
					end
				end
				S_D0: begin
					if (dgain_q == '0) begin
						state_q <= S_SUM;
					end else begin
						mul_go_q <= 1'b1;
						state_q  <= S_D1;
					end
				end
				S_D1: begin
					if (mul_stat.done) begin
						mul_go_q <= 1'b1;
						state_q  <= S_D2;
					end
				end
				S_D2: begin
					if (mul_stat.done) begin
						mul_go_q <= 1'b1;
						state_q  <= S_D3;
					end
				end
				S_D3: begin
					if (mul_stat.done) begin
						dmem_q  <= dmem_c;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					kind_q   <= kind;
					tgt_q    <= target;
					meas_q   <= measured;
					dt_q     <= time_step;
					preset_q <= integ_preset;
				end
			end
			S_PREP: begin
				pt_q    <= '0;
				it_q    <= '0;
				dterm_q <= '0;
				diff_q  <= diff_c;
				mul_a_q <= pgain_q;
				mul_b_q <= err_c;
				div_n_q <= preset_q;
				div_d_q <= igain_q;
			end
			S_P: begin
				if (mul_stat.done) begin
					pt_q    <= clampsym(mul_res, plim_q);
					mul_a_q <= igain_q;
					mul_b_q <= esum_q;
				end
			end
			S_I1: begin
				if (mul_stat.done) begin
					mul_a_q <= mul_res;
					mul_b_q <= {{(W-F){1'b0}}, dt_q};
				end
			end
			S_I2: begin
				if (mul_stat.done) begin
					it_q    <= itc_c;
					div_n_q <= itc_c;
					div_d_q <= igain_q;
				end
			end
			S_D0: begin
				mul_a_q <= dgain_q;
				mul_b_q <= {{(W-F-1){1'b0}}, dfilt_q};
			end
			S_D1: begin
				if (mul_stat.done) begin
					mul_a_q <= mul_res;
					mul_b_q <= diff_q;
				end
			end
			S_D2: begin
				if (mul_stat.done) begin
					dterm_q <= clampsym(mul_res, dlim_q);
					mul_a_q <= {{(W-F-1){1'b0}}, dfilt_q};
					mul_b_q <= diff_q;
				end
			end
			S_SUM: begin
				if (!out_valid_q || out_ready)
					drive_q <= clampsym(sum_c, olim_q);
			end
			default: ;
		endcase
	end

	// the two serial units never run at once
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_stat.busy && div_stat.busy))
		else $error("multiplier and divider busy together");

	// final sum is formed only after all serial work has finished
	a_sum_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> (!mul_stat.busy && !div_stat.busy))
		else $error("sum taken while a serial unit is busy");

	// a multiply request starts the unit on the next cycle
	a_mul_starts: assert property (@(posedge clk) disable iff (!arst_n)
		mul_go_q |=> mul_stat.busy)
		else $error("multiply request lost");

	// a presented result respects the output clamp
	a_drive_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($signed(drive_q) <= $signed({1'b0, olim_q}) &&
		                 $signed(drive_q) >= -$signed({1'b0, olim_q})))
		else $error("drive outside output limit");

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import pidct_pkg::*;

	localparam int VW = 32;
	localparam int FB = 16;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [VW-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] kind;
	logic [VW-1:0] target;
	logic [VW-1:0] measured;
	logic [FB-1:0] time_step;
	logic [VW-1:0] integ_preset;
	logic out_valid;
	logic out_ready;
	logic [VW-1:0] drive;

	pid_controller_clamped_terms uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .target(target),
		.measured(measured), .time_step(time_step), .integ_preset(integ_preset),
		.out_valid(out_valid), .out_ready(out_ready), .drive(drive)
	);

	// controller state and settings as the checker sees them
	longint kp, ki, kd, dfilt, lim_p, lim_i, lim_d, lim_out;
	longint err_acc, dmem;

	logic [VW-1:0] drive_q[$];
	int fails;
	int send_idle_pct, recv_idle_pct;
	bit recv_hold;

	typedef struct {
		logic [1:0] k;
		logic [VW-1:0] tg, ms, ip;
		logic [FB-1:0] dt;
		bit known;
		logic [VW-1:0] want;
	} stim_row_t;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("pid_controller_clamped_terms: mismatch");
		$finish;
	end

	function automatic longint sat(longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	// exact product, truncated toward zero by FB bits, saturated
	function automatic longint qmul(longint a, longint b);
		logic signed [127:0] p;
		logic [127:0] m;
		bit neg;
		p = 128'(signed'(a)) * 128'(signed'(b));
		neg = p[127];
		m = neg ? -p : p;
		m = m >> FB;
		if (!neg) return (m > 128'(VMAX)) ? VMAX : longint'(m);
		return (m > 128'(VMAX) + 1) ? VMIN : -longint'(m);
	endfunction

	// (num << FB) / den, toward zero, saturated; den nonzero
	function automatic longint qdiv(longint num, longint den);
		logic [127:0] n, d, q;
		bit neg;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? 128'(-num) : 128'(num);
		d = (den < 0) ? 128'(-den) : 128'(den);
		q = (n << FB) / d;
		if (!neg) return (q > 128'(VMAX)) ? VMAX : longint'(q);
		return (q > 128'(VMAX) + 1) ? VMIN : -longint'(q);
	endfunction

	function automatic longint clamp_sym(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic logic [VW-1:0] pid_step(logic [1:0] k, logic [VW-1:0] tg,
			logic [VW-1:0] ms, logic [FB-1:0] dt, logic [VW-1:0] ip);
		longint t, m, p, e, pt, it, dterm, diff, out;
		t = longint'(signed'(tg));
		m = longint'(signed'(ms));
		p = longint'(signed'(ip));
		out = 0;
		dterm = 0;
		case (k)
			KIND_UPDATE: begin
				e = sat(t - m);
				pt = clamp_sym(qmul(kp, e), lim_p);
				err_acc = sat(err_acc + e);
				it = qmul(qmul(ki, err_acc), longint'(dt));
				if (it > lim_i || it < -lim_i) begin
					// anti-windup: pull the sum back to what the limit allows
					it = (it > 0) ? lim_i : -lim_i;
					if (ki != 0) err_acc = qdiv(it, ki);
				end
				if (kd != 0) begin
					diff = sat(sat(-m) - dmem);
					dterm = qmul(qmul(kd, dfilt), diff);
					dmem = sat(dmem + qmul(dfilt, diff));
					dterm = clamp_sym(dterm, lim_d);
				end
				out = clamp_sym(sat(pt + it + dterm), lim_out);
			end
			KIND_PRESET: begin
				if (ki != 0) err_acc = qdiv(p, ki);
				dmem = sat(-m);
			end
			KIND_CLEAR: begin
				err_acc = 0;
				dmem = 0;
			end
			default: ;
		endcase
		return out[VW-1:0];
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [VW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PROP_GAIN:    kp = longint'(signed'(val));
			REG_INTEG_GAIN:   ki = longint'(signed'(val));
			REG_DERIV_GAIN:   kd = longint'(signed'(val));
			REG_DERIV_FILTER: dfilt = longint'(val[FB:0]);
			REG_PROP_LIMIT:   lim_p = longint'(val[VW-2:0]);
			REG_INTEG_LIMIT:  lim_i = longint'(val[VW-2:0]);
			REG_DERIV_LIMIT:  lim_d = longint'(val[VW-2:0]);
			REG_OUTPUT_LIMIT: lim_out = longint'(val[VW-2:0]);
			default: ;
		endcase
		@(negedge clk);
	endtask

	// every item yields a drive, so an empty queue means idle; a little slack anyway
	task automatic drain();
		in_valid <= 1'b0;
		while (drive_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// one transfer on the input channel; predicted drive queued at acceptance
	task automatic send_item(logic [1:0] k, logic [VW-1:0] tg, logic [VW-1:0] ms,
			logic [FB-1:0] dt, logic [VW-1:0] ip, bit known, logic [VW-1:0] want);
		logic [VW-1:0] pred;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		target <= tg;
		measured <= ms;
		time_step <= dt;
		integ_preset <= ip;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = pid_step(k, tg, ms, dt, ip);
		if (known && pred !== want)
			$display("%0t table row disagrees with predictor: %h vs %h", $time, want, pred);
		drive_q.push_back(known ? want : pred);
		@(negedge clk);
	endtask

	function automatic logic [VW-1:0] rand_val();
		case ($urandom_range(7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(400000)) - 200000);
			3: return 32'($signed($urandom_range(8)) - 4) << 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [VW-1:0] rand_gain();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			3: return $urandom;
			default: return 32'($signed($urandom_range(262144)) - 131072);
		endcase
	endfunction

	function automatic logic [VW-1:0] rand_limit();
		case ($urandom_range(4))
			0: return 32'h0;
			1: return 32'h7fffffff;
			2: return {1'b0, 31'($urandom)};
			default: return 32'($urandom_range(1 << 22));
		endcase
	endfunction

	task automatic random_settings();
		write_reg(REG_PROP_GAIN, rand_gain());
		write_reg(REG_INTEG_GAIN, rand_gain());
		write_reg(REG_DERIV_GAIN, rand_gain());
		write_reg(REG_DERIV_FILTER, ($urandom_range(3) == 0) ? 32'h10000 :
			32'($urandom_range(32'h10000)));
		write_reg(REG_PROP_LIMIT, rand_limit());
		write_reg(REG_INTEG_LIMIT, rand_limit());
		write_reg(REG_DERIV_LIMIT, rand_limit());
		write_reg(REG_OUTPUT_LIMIT, rand_limit());
	endtask

	task automatic random_item();
		logic [1:0] k;
		int r;
		logic [FB-1:0] dt;
		r = $urandom_range(99);
		// mostly updates so the integrator and filter build up history
		k = (r < 85) ? KIND_UPDATE : (r < 93) ? KIND_PRESET : (r < 97) ? KIND_CLEAR
			: KIND_UNUSED;
		dt = ($urandom_range(4) == 0) ? 16'hffff : 16'($urandom);
		send_item(k, rand_val(), rand_val(), dt, rand_val(), 1'b0, '0);
	endtask

	// receiver: random stalls, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (arst_n) out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (drive_q.size() == 0) begin
				$display("%0t unexpected drive transfer: %h", $time, drive);
				fails++;
			end else begin
				if (drive !== drive_q[0]) begin
					$display("%0t drive mismatch: expected %h actual %h",
						$time, drive_q[0], drive);
					fails++;
				end
				void'(drive_q.pop_front());
			end
		end
	end

	stim_row_t rows[$];

	task automatic add_row(logic [1:0] k, logic [VW-1:0] tg, logic [VW-1:0] ms,
			logic [FB-1:0] dt, logic [VW-1:0] ip, bit known, logic [VW-1:0] want);
		stim_row_t r;
		r.k = k; r.tg = tg; r.ms = ms; r.dt = dt; r.ip = ip;
		r.known = known; r.want = want;
		rows.push_back(r);
	endtask

	initial begin
		int n;
		fails = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; kind = '0; target = '0; measured = '0;
		time_step = '0; integ_preset = '0;
		out_ready = 1'b0;
		recv_hold = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		kp = 0; ki = 0; kd = 0; dfilt = 64'h10000;
		lim_p = VMAX; lim_i = VMAX; lim_d = VMAX; lim_out = VMAX;
		err_acc = 0; dmem = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// after reset all gains are zero: drive is zero whatever comes in
		add_row(KIND_UPDATE, 32'h7fffffff, 32'h80000000, 16'hffff, 0, 1'b1, 0);
		add_row(KIND_UPDATE, 32'h80000000, 32'h7fffffff, 16'hffff, 0, 1'b1, 0);
		add_row(KIND_PRESET, 0, 32'h80000000, 0, 32'h7fffffff, 1'b1, 0);
		add_row(KIND_CLEAR, 32'hffffffff, 32'hffffffff, 16'hffff, 32'hffffffff, 1'b1, 0);
		add_row(KIND_UNUSED, 32'h12345678, 32'h9abcdef0, 16'h5555, 32'haaaaaaaa, 1'b1, 0);
		foreach (rows[i])
			send_item(rows[i].k, rows[i].tg, rows[i].ms, rows[i].dt, rows[i].ip,
				rows[i].known, rows[i].want);
		drain();

		// P only, gain 1.0: drive follows the error, then the symmetric clamp at the ends
		write_reg(REG_PROP_GAIN, 32'h00010000);
		rows.delete();
		add_row(KIND_UPDATE, 32'h00030000, 32'h00010000, 0, 0, 1'b1, 32'h00020000);
		add_row(KIND_UPDATE, 32'h7fffffff, 32'h80000000, 0, 0, 1'b1, 32'h7fffffff);
		add_row(KIND_UPDATE, 32'h80000000, 32'h7fffffff, 0, 0, 1'b1, 32'h80000001);
		foreach (rows[i])
			send_item(rows[i].k, rows[i].tg, rows[i].ms, rows[i].dt, rows[i].ip,
				rows[i].known, rows[i].want);
		drain();

		// small limits, all terms active: integrator clamp-back, D filter, preset
		write_reg(REG_PROP_LIMIT, 32'h00020000);
		write_reg(REG_INTEG_GAIN, 32'h00020000);
		write_reg(REG_INTEG_LIMIT, 32'h00008000);
		write_reg(REG_DERIV_GAIN, 32'hffff0000);
		write_reg(REG_DERIV_FILTER, 32'h00004000);
		write_reg(REG_DERIV_LIMIT, 32'h00030000);
		write_reg(REG_OUTPUT_LIMIT, 32'h00040000);
		rows.delete();
		add_row(KIND_UPDATE, 32'h00100000, 0, 16'hffff, 0, 1'b0, 0);
		add_row(KIND_UPDATE, 32'h00100000, 32'h00050000, 16'h8000, 0, 1'b0, 0);
		add_row(KIND_UPDATE, 32'h80000000, 32'h7fffffff, 16'hffff, 0, 1'b0, 0);
		add_row(KIND_PRESET, 0, 32'h80000000, 0, 32'h80000000, 1'b1, 0);
		add_row(KIND_UPDATE, 0, 32'h00010000, 16'h0001, 0, 1'b0, 0);
		add_row(KIND_PRESET, 0, 32'h7fffffff, 0, 32'h7fffffff, 1'b1, 0);
		add_row(KIND_UPDATE, 32'h7fffffff, 0, 16'hffff, 0, 1'b0, 0);
		foreach (rows[i])
			send_item(rows[i].k, rows[i].tg, rows[i].ms, rows[i].dt, rows[i].ip,
				rows[i].known, rows[i].want);
		drain();

		// zero integral gain: clamp-back leaves the sum alone; zero limits
		write_reg(REG_INTEG_GAIN, 0);
		write_reg(REG_INTEG_LIMIT, 0);
		write_reg(REG_DERIV_GAIN, 0);
		write_reg(REG_OUTPUT_LIMIT, 0);
		rows.delete();
		add_row(KIND_UPDATE, 32'h00100000, 0, 16'hffff, 0, 1'b1, 0);
		add_row(KIND_PRESET, 0, 32'h00010000, 0, 32'h00050000, 1'b1, 0);
		add_row(KIND_CLEAR, 0, 0, 0, 0, 1'b1, 0);
		foreach (rows[i])
			send_item(rows[i].k, rows[i].tg, rows[i].ms, rows[i].dt, rows[i].ip,
				rows[i].known, rows[i].want);
		drain();

		// random phases: sender idles lightly, receiver heavily; then swapped; then none
		for (int ph = 0; ph < 12; ph++) begin
			random_settings();
			if (ph < 4) begin
				send_idle_pct = 16; recv_idle_pct = 88;
			end else if (ph < 8) begin
				send_idle_pct = 88; recv_idle_pct = 16;
			end else begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			if (ph == 9) begin
				// long receiver hold-off while items keep coming
				fork
					begin
						recv_hold = 1'b1;
						repeat (2000) @(negedge clk);
						recv_hold = 1'b0;
					end
				join_none
			end
			n = (ph < 8) ? 60 : 165;
			for (int j = 0; j < n; j++) begin
				random_item();
				// sender pause until everything is back
				if (j == n / 2 && ph == 5) drain();
			end
			drain();
		end

		repeat (300) @(negedge clk);
		if (fails == 0 && drive_q.size() == 0)
			$display("pid_controller_clamped_terms: match");
		else
			$display("pid_controller_clamped_terms: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
rtl/pidct_pkg.sv
rtl/pidct_mul.sv
rtl/pidct_div.sv
rtl/pid_controller_clamped_terms.sv
sim/testbench.sv
